### design/kdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_pkg: shared types and constants for the key debounce/press classifier
// Widths, opcodes, press-state codes, register indexes and the layout of one
// per-key counter entry.
// ----------------------------------------------------------------------------
package kdpc_pkg;

   // Key array and counter sizing
   localparam int KEY_COUNT   = 5;
   localparam int COUNT_WIDTH = 16;
   localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   // Fixed field widths
   localparam int OP_W      = 2;
   localparam int SEL_W     = 3;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int STATE_W   = 3;
   localparam int STATES_W  = STATE_W * KEY_COUNT;

   // Compare widths
   localparam int SEL_CMP_W = (KEY_IDX_W > SEL_W) ? KEY_IDX_W : SEL_W;
   localparam int CNT_CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   // Stream data widths, padded to whole bytes; the user width is not padded
   localparam int REQ_TDATA_W = ((KEY_COUNT + 7) / 8) * 8;
   localparam int REQ_TUSER_W = OP_W + SEL_W;
   localparam int RSP_TDATA_W = ((STATES_W + 7) / 8) * 8;

   // Register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(2);
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(100);
   localparam logic             RELEASED_RST   = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_SCAN      = 2'd0,
      OP_CLEAR_ONE = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      PS_RELEASE   = 3'd0,
      PS_JUST      = 3'd1,
      PS_HOLD      = 3'd2,
      PS_LONG      = 3'd3,
      PS_SHORT_REL = 3'd4
   } press_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE       = 2'd0,
      CSR_LONG_PRESS     = 2'd1,
      CSR_RELEASED_LEVEL = 2'd2
   } csr_idx_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // One entry of the per-key counter memory
   typedef struct packed {
      logic      level;
      count_type stable;
      count_type press;
   } entry_type;

   // Live configuration handed to the update unit
   typedef struct packed {
      logic [CFG_W-1:0] debounce;
      logic [CFG_W-1:0] long_press;
      logic             released_level;
   } cfg_type;

   // Saturating increment
   function automatic count_type sat_inc(input count_type v);
      return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage

### design/key_debounce_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_press_classifier: multi-key debounce and press classifier
// Each beat runs a sweep over all keys: counters are read from a small
// synchronous memory, updated and written back; press states live in flops
// and the packed states after the sweep form one result beat.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tdata: key_levels; tuser: operation, key_select
//  rsp_    | out | tdata: key_states (3 bits per key)
//  csr_    | in  | write enable, register index, 16-bit write data
//
//  An item is swept as one memory read-modify-write per key, paced by the
//  single read port. The next item's sweep starts the cycle after the last
//  key of the current one issues, so items run back to back.
//  The result leaves from an output register, loaded when the last key passes
//  the update stage; a held result stalls the sweep only when the next one is done.
//  Synchronous reset clears control, registers and per-entry valid bits;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kdpc_pkg::REQ_TDATA_W-1:0] req_tdata,  // [4:0] key_levels
   input  logic [kdpc_pkg::REQ_TUSER_W-1:0] req_tuser,  // [1:0] operation, [4:2] key_select
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kdpc_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [14:0] key_states
   // configuration writes
   input  logic                             csr_we,
   input  logic [kdpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kdpc_pkg::CFG_W-1:0]       csr_wdata
);
   import kdpc_pkg::*;

   localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(KEY_COUNT - 1);

   // Configuration registers
   cfg_type cfg_ff;

   // Issue stage: item being swept
   logic                   a_busy_ff;
   logic [KEY_IDX_W-1:0]   a_key_ff;
   op_type                 a_op_ff;
   logic [KEY_COUNT-1:0]   a_levels_ff;
   logic [SEL_W-1:0]       a_sel_ff;

   // Update stage
   logic                   b_valid_ff;
   logic                   b_last_ff;
   logic [KEY_IDX_W-1:0]   b_key_ff;
   op_type                 b_op_ff;
   logic                   b_level_ff;
   logic [SEL_W-1:0]       b_sel_ff;

   // Counter memory with per-entry valid bits
   entry_type              mem [KEY_COUNT];
   logic [KEY_COUNT-1:0]   entry_valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   // Press states and result register
   press_type              press_state_ff [KEY_COUNT];
   press_type              press_state_in [KEY_COUNT];
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATES_W-1:0]    rsp_data_ff;
   logic [STATES_W-1:0]    states_in;

   logic                   stall;
   logic                   a_issue;
   logic                   a_last;
   logic                   req_fire;
   logic                   b_fire;
   entry_type              cur_entry;
   entry_type              new_entry;
   press_type              new_state;
   logic                   entry_we;
   logic                   wr_en;
   logic                   sel_hit;

   // Handshake and pipeline control
   assign stall      = b_valid_ff && b_last_ff && rsp_valid_ff && !rsp_tready;
   assign a_last     = a_key_ff == LAST_KEY;
   assign a_issue    = a_busy_ff && !stall;
   assign req_tready = (!a_busy_ff || a_last) && !stall;
   assign req_fire   = req_tvalid && req_tready;
   assign b_fire     = b_valid_ff && !stall;

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce       <= DEBOUNCE_RST;
         cfg_ff.long_press     <= LONG_PRESS_RST;
         cfg_ff.released_level <= RELEASED_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE:       cfg_ff.debounce       <= csr_wdata;
            CSR_LONG_PRESS:     cfg_ff.long_press     <= csr_wdata;
            CSR_RELEASED_LEVEL: cfg_ff.released_level <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Issue stage: load an item, then step the key index
   always_ff @(posedge clock) begin
      if (reset) begin
         a_busy_ff <= 1'b0;
         a_key_ff  <= '0;
      end else begin
         if (req_fire) begin
            a_busy_ff <= 1'b1;
            a_key_ff  <= '0;
         end else if (a_issue) begin
            a_busy_ff <= !a_last;
            a_key_ff  <= a_last ? '0 : a_key_ff + KEY_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_op_ff     <= op_type'(req_tuser[OP_W-1:0]);
         a_sel_ff    <= req_tuser[OP_W +: SEL_W];
         a_levels_ff <= req_tdata[KEY_COUNT-1:0];
      end
   end

   // Update stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!stall) begin
         b_valid_ff <= a_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_issue) begin
         b_last_ff  <= a_last;
         b_key_ff   <= a_key_ff;
         b_op_ff    <= a_op_ff;
         b_level_ff <= a_levels_ff[a_key_ff];
         b_sel_ff   <= a_sel_ff;
      end
   end

   // Counter memory: write back from update stage, registered read with bypass
   assign wr_en = b_fire && entry_we;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[b_key_ff] <= new_entry;
      end
      if (a_issue) begin
         if (wr_en && (b_key_ff == a_key_ff)) begin
            rd_data_ff <= new_entry;
         end else begin
            rd_data_ff <= mem[a_key_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[b_key_ff] <= 1'b1;
         end
         if (a_issue) begin
            rd_valid_ff <= entry_valid_ff[a_key_ff] || (wr_en && (b_key_ff == a_key_ff));
         end
      end
   end

   // Never-written entries read as the reset contents
   always_comb begin
      if (rd_valid_ff) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry.level  = RELEASED_RST;
         cur_entry.stable = '0;
         cur_entry.press  = '0;
      end
   end

   assign sel_hit = SEL_CMP_W'(b_sel_ff) == SEL_CMP_W'(b_key_ff);

   kdpc_key_update u_update (
      .cur_entry (cur_entry),
      .cur_state (press_state_ff[b_key_ff]),
      .level     (b_level_ff),
      .op        (b_op_ff),
      .sel_hit   (sel_hit),
      .cfg       (cfg_ff),
      .new_entry (new_entry),
      .new_state (new_state),
      .entry_we  (entry_we)
   );

   // Press states after this key's update, packed for the result
   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         press_state_in[k] = press_state_ff[k];
         if (b_fire && (b_key_ff == KEY_IDX_W'(k))) begin
            press_state_in[k] = new_state;
         end
         states_in[STATE_W*k +: STATE_W] = press_state_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            press_state_ff[k] <= PS_RELEASE;
         end
      end else begin
         press_state_ff <= press_state_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (b_fire && b_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && b_last_ff) begin
         rsp_data_ff <= states_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Checks
   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> a_busy_ff && (a_key_ff == '0))
      else $error("accepted beat did not start a sweep at key 0");

   a_last_key_gives_result: assert property (@(posedge clock) disable iff (reset)
      b_fire && b_last_ff |=> rsp_valid_ff)
      else $error("finished sweep produced no result");

   a_stall_holds_update: assert property (@(posedge clock) disable iff (reset)
      stall |=> b_valid_ff && $stable(b_key_ff) && $stable(b_last_ff))
      else $error("update stage moved during a stall");

   a_no_accept_mid_sweep: assert property (@(posedge clock) disable iff (reset)
      a_busy_ff && !a_last |-> !req_tready)
      else $error("beat accepted while a sweep was still issuing");

endmodule

### design/kdpc_key_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_key_update: per-key debounce and press classification
// Takes one key's counter entry and press state plus the operation, returns
// the updated entry, its write enable and the new press state.
// ----------------------------------------------------------------------------
module kdpc_key_update (
   input  kdpc_pkg::entry_type cur_entry,
   input  kdpc_pkg::press_type cur_state,
   input  logic                level,
   input  kdpc_pkg::op_type    op,
   input  logic                sel_hit,
   input  kdpc_pkg::cfg_type   cfg,
   output kdpc_pkg::entry_type new_entry,
   output kdpc_pkg::press_type new_state,
   output logic                entry_we
);
   import kdpc_pkg::*;

   count_type stable_n;
   count_type press_n;
   logic      settled;
   logic      pressed;
   logic      clearable;

   always_comb begin
      // stable counter restarts on any level change
      stable_n  = (level != cur_entry.level) ? '0 : sat_inc(cur_entry.stable);
      press_n   = sat_inc(cur_entry.press);
      settled   = CNT_CMP_W'(stable_n) >= CNT_CMP_W'(cfg.debounce);
      pressed   = level != cfg.released_level;
      clearable = (cur_state == PS_JUST) || (cur_state == PS_SHORT_REL);

      new_entry = cur_entry;
      new_state = cur_state;
      entry_we  = 1'b0;

      case (op)
         OP_SCAN: begin
            entry_we         = 1'b1;
            new_entry.level  = level;
            new_entry.stable = stable_n;
            if (settled) begin
               if (pressed) begin
                  new_entry.press = press_n;
                  if (press_n == COUNT_WIDTH'(1)) begin
                     new_state = PS_JUST;
                  end else if (CNT_CMP_W'(press_n) >= CNT_CMP_W'(cfg.long_press)) begin
                     new_state = PS_LONG;
                  end else if (cur_state != PS_LONG) begin
                     new_state = PS_HOLD;
                  end
               end else begin
                  // release: short or long depending on the count reached
                  if ((cur_state == PS_HOLD) || (cur_state == PS_JUST) ||
                      (cur_state == PS_LONG)) begin
                     new_state = (CNT_CMP_W'(cur_entry.press) < CNT_CMP_W'(cfg.long_press))
                                 ? PS_SHORT_REL : PS_RELEASE;
                  end
                  new_entry.press = '0;
               end
            end
         end
         OP_CLEAR_ONE: begin
            if (sel_hit && clearable) begin
               new_state = PS_RELEASE;
            end
         end
         OP_CLEAR_ALL: begin
            if (clearable) begin
               new_state = PS_RELEASE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### tb/key_debounce_press_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_test: self-checking bench for the classifier
// Feeds scan ticks and clear beats through the request stream and tracks the
// debounce counters and press states of every key in a local predictor. Each
// result beat is checked against the oldest predicted key_states. Random gaps
// and back-pressure are applied. The registers are reprogrammed between
// phases, from the extremes to small random thresholds.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_test;
   import kdpc_pkg::*;

   typedef struct packed {
      op_type                op;
      logic [KEY_COUNT-1:0]  levels;
      logic [SEL_W-1:0]      sel;
   } key_beat_type;

   // DUT connections
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;  // [4:0] key_levels
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;  // [1:0] operation, [4:2] key_select
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;        // [14:0] key_states
   logic                    csr_we     = 1'b0;
   csr_idx_type             csr_index  = CSR_DEBOUNCE;
   logic [CFG_W-1:0]        csr_wdata  = '0;

   // Predictor state per key, and its copy of the registers
   logic                    level_seen   [KEY_COUNT];
   count_type               stable_ticks [KEY_COUNT];
   count_type               press_ticks  [KEY_COUNT];
   press_type               press_pred   [KEY_COUNT];
   logic [CFG_W-1:0]        debounce_cfg;
   logic [CFG_W-1:0]        long_press_cfg;
   logic                    released_cfg;

   // Stimulus and expected-result stores
   key_beat_type            beat_queue [$];
   logic [STATES_W-1:0]     states_due [$];
   int                      mismatch_count = 0;
   int                      req_gap_max    = 7;
   int                      rsp_stall_max  = 7;

   // Driver and monitor bookkeeping
   key_beat_type            live_beat;
   bit                      beat_live = 1'b0;
   int                      gap_left  = 0;
   int                      stall_left = 0;

   key_debounce_press_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #4 clock = ~clock;

   // Just-pressed and short-release fall back to release on a clear
   function automatic void clear_flag(input int k);
      if (press_pred[k] == PS_JUST || press_pred[k] == PS_SHORT_REL)
         press_pred[k] = PS_RELEASE;
   endfunction

   // Apply one beat to the predictor and return the packed states after it
   function automatic logic [STATES_W-1:0] classify_beat(input key_beat_type beat);
      logic [STATES_W-1:0] states;
      logic                lvl;
      int                  k;
      states = '0;
      case (beat.op)
         OP_SCAN: begin
            for (k = 0; k < KEY_COUNT; k++) begin
               lvl = beat.levels[k];
               // level change restarts the debounce window
               if (lvl != level_seen[k]) begin
                  stable_ticks[k] = '0;
                  level_seen[k]   = lvl;
               end else if (stable_ticks[k] != '1) begin
                  stable_ticks[k] = stable_ticks[k] + 1'b1;
               end
               if (stable_ticks[k] >= debounce_cfg) begin
                  if (lvl != released_cfg) begin
                     if (press_ticks[k] != '1)
                        press_ticks[k] = press_ticks[k] + 1'b1;
                     if (press_ticks[k] == count_type'(1))
                        press_pred[k] = PS_JUST;
                     else if (press_ticks[k] >= long_press_cfg)
                        press_pred[k] = PS_LONG;
                     else if (press_pred[k] != PS_LONG)
                        press_pred[k] = PS_HOLD;
                  end else begin
                     if (press_pred[k] == PS_JUST || press_pred[k] == PS_HOLD ||
                         press_pred[k] == PS_LONG)
                        press_pred[k] = (press_ticks[k] < long_press_cfg) ?
                                        PS_SHORT_REL : PS_RELEASE;
                     press_ticks[k] = '0;
                  end
               end
            end
         end
         OP_CLEAR_ONE: begin
            if (beat.sel < KEY_COUNT)
               clear_flag(int'(beat.sel));
         end
         OP_CLEAR_ALL: begin
            for (k = 0; k < KEY_COUNT; k++)
               clear_flag(k);
         end
         default: ;
      endcase
      for (k = 0; k < KEY_COUNT; k++)
         states[STATE_W*k +: STATE_W] = press_pred[k];
      return states;
   endfunction

   task automatic queue_beat(input op_type op, input logic [KEY_COUNT-1:0] levels,
                             input logic [SEL_W-1:0] sel);
      key_beat_type beat;
      beat.op     = op;
      beat.levels = levels;
      beat.sel    = sel;
      beat_queue.push_back(beat);
   endtask

   // Nothing pending, nothing on the bus, nothing owed
   task automatic wait_idle();
      while (beat_queue.size() != 0 || beat_live || states_due.size() != 0)
         @(posedge clock);
   endtask

   // Write all three registers while the block is idle
   task automatic program_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                               input logic rel);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= lng;
      @(posedge clock);
      // upper bits are don't-care for the level register
      csr_index <= CSR_RELEASED_LEVEL;
      csr_wdata <= (CFG_W'($urandom) << 1) | CFG_W'(rel);
      @(posedge clock);
      csr_we <= 1'b0;
      debounce_cfg   = deb;
      long_press_cfg = lng;
      released_cfg   = rel;
   endtask

   // Request driver: one beat at a time, random gap after each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         beat_live = 1'b0;
         gap_left  = 0;
      end else begin
         if (beat_live && req_tready) begin
            states_due.push_back(classify_beat(live_beat));
            beat_live = 1'b0;
            gap_left  = $urandom_range(0, req_gap_max);
         end
         if (!beat_live) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (beat_queue.size() > 0) begin
               live_beat = beat_queue.pop_front();
               beat_live = 1'b1;
               req_tdata <= REQ_TDATA_W'(live_beat.levels);
               req_tuser <= {live_beat.sel, live_beat.op};
            end
         end
         req_tvalid <= beat_live;
      end
   end

   // Result monitor: check each beat, then stall a random number of cycles
   always @(posedge clock) begin
      logic [STATES_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (states_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 200)
                  $display("%0t: key_states expected none, got %05o", $time,
                           rsp_tdata[STATES_W-1:0]);
            end else begin
               want = states_due.pop_front();
               if (rsp_tdata[STATES_W-1:0] !== want) begin
                  mismatch_count++;
                  // keep the log short if the block is badly off
                  if (mismatch_count <= 200)
                     $display("%0t: key_states expected %05o, got %05o", $time, want,
                              rsp_tdata[STATES_W-1:0]);
               end
            end
            stall_left = $urandom_range(0, rsp_stall_max);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus sequence
   initial begin
      key_beat_type          beat;
      logic [KEY_COUNT-1:0]  held;
      int                    pick;
      int                    phase;
      int                    n;
      int                    k;

      // predictor starts from the reset state
      for (k = 0; k < KEY_COUNT; k++) begin
         level_seen[k]   = RELEASED_RST;
         stable_ticks[k] = '0;
         press_ticks[k]  = '0;
         press_pred[k]   = PS_RELEASE;
      end
      debounce_cfg   = DEBOUNCE_RST;
      long_press_cfg = LONG_PRESS_RST;
      released_cfg   = RELEASED_RST;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset thresholds: release without press, press, clears
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h1F, 3'd7);
      queue_beat(OP_SCAN, 5'h00, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);        // just pressed on all keys
      queue_beat(OP_CLEAR_ONE, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);        // short hold
      queue_beat(OP_CLEAR_ALL, 5'h00, 3'd0);   // hold is not cleared
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);        // short release
      queue_beat(OP_CLEAR_ONE, 5'h00, 3'd2);
      queue_beat(OP_CLEAR_ONE, 5'h00, 3'd5);   // selector past last key
      queue_beat(OP_CLEAR_ONE, 5'h1F, 3'd7);
      queue_beat(OP_NOP, 5'h00, 3'd3);
      queue_beat(OP_CLEAR_ALL, 5'h1F, 3'd7);
      queue_beat(OP_SCAN, 5'h15, 3'd0);
      queue_beat(OP_SCAN, 5'h0A, 3'd0);

      // Zero debounce, zero long threshold, inverted released level
      program_regs(16'd0, 16'd0, 1'b0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);

      // Long threshold of one
      program_regs(16'd0, 16'd1, 1'b0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h1F, 3'd0);
      queue_beat(OP_SCAN, 5'h00, 3'd0);

      // Random phases: held levels with bounces, clears and noise
      held = '0;
      for (phase = 0; phase < 8; phase++) begin
         program_regs(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 30)),
                      1'($urandom_range(0, 1)));
         req_gap_max   = (phase % 3 == 2) ? 0 : 7;
         rsp_stall_max = (phase % 4 == 3) ? 0 : 7;
         for (n = 0; n < 250; n++) begin
            pick        = $urandom_range(0, 99);
            beat.op     = OP_SCAN;
            beat.levels = KEY_COUNT'($urandom);
            beat.sel    = SEL_W'($urandom);
            if (pick < 4) begin
               held        = KEY_COUNT'($urandom);
               beat.levels = held;
            end else if (pick < 10) begin
               held[$urandom_range(0, KEY_COUNT-1)] ^= 1'b1;
               beat.levels = held;
            end else if (pick < 78) begin
               beat.levels = held;
            end else if (pick < 84) begin
               // one-tick glitch, held level unchanged
            end else if (pick < 92) begin
               beat.op = OP_CLEAR_ONE;
            end else if (pick < 97) begin
               beat.op = OP_CLEAR_ALL;
            end else begin
               beat.op = OP_NOP;
            end
            beat_queue.push_back(beat);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Run limit
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
